>>> rtl/bftr_pkg.sv
// Package: shared types, codes, defaults and the character-to-cell lookup for the text renderer.
`timescale 1ns / 1ps

package bftr_pkg;

  // Default geometry
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;
  localparam int DEF_CELL_WIDTH    = 16;
  localparam int DEF_CELL_HEIGHT   = 22;
  localparam int DEF_ATLAS_WIDTH   = 208;
  localparam int DEF_ATLAS_BYTES   = 2048;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_PEN  = 2'd1,
    KIND_DRAW = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_DONE
  } state_t;

  // Character codes that bound the cell map
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic [1:0] row;
    logic [3:0] col;
  } cell_pos_t;

  // Map a code to its cell in the 13-wide map; unknown codes give the blank cell.
  function automatic cell_pos_t glyph_cell(input logic [7:0] code);
    cell_pos_t p;
    p.row = 2'd0;
    p.col = 4'd0;
    if (code >= CH_A && code <= CH_L) begin
      p.col = 4'(code - CH_A + 8'd1);
    end else if (code >= CH_M && code <= CH_Y) begin
      p.row = 2'd1;
      p.col = 4'(code - CH_M);
    end else if (code == CH_Z) begin
      p.row = 2'd2;
    end else if (code >= CH_0 && code <= CH_COLON) begin
      p.row = 2'd2;
      p.col = 4'(code - CH_0 + 8'd1);
    end else if (code == CH_X) begin
      p.row = 2'd2;
      p.col = 4'd12;
    end
    return p;
  endfunction

endpackage

>>> rtl/bftr_if.sv
// Interfaces: input item channel and result row channel of the text renderer.
`timescale 1ns / 1ps

interface bftr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [10:0]        atlas_addr;
  logic [7:0]         atlas_byte;
  logic [7:0]         char_code;
  logic signed [15:0] pen_x_in;
  logic signed [15:0] pen_y_in;
  logic [15:0]        color_in;

  modport source (
    output valid, kind, atlas_addr, atlas_byte, char_code, pen_x_in, pen_y_in, color_in,
    input  ready
  );
  modport sink (
    input  valid, kind, atlas_addr, atlas_byte, char_code, pen_x_in, pen_y_in, color_in,
    output ready
  );
endinterface

interface bftr_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         screen_y;
  logic signed [15:0] screen_x;
  logic [15:0]        write_mask;
  logic [15:0]        color;
  logic               last;

  modport source (
    output valid, screen_y, screen_x, write_mask, color, last,
    input  ready
  );
  modport sink (
    input  valid, screen_y, screen_x, write_mask, color, last,
    output ready
  );
endinterface

>>> rtl/bftr_atlas.sv
// Glyph atlas RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module bftr_atlas #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    rdata_a,
  output logic [7:0]    rdata_b
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/bitmap_font_text_renderer.sv
// Load, set-pen and unused items are taken in idle; ready is high whenever the sequencer idles.
// A draw item runs a setup step, walks the glyph rows and drains the fetch stage. One glyph
// row is fetched per cycle through the two read ports of the atlas RAM unless the output stalls.
// When glyph rows straddle three atlas bytes, a row reads its first two bytes, then its third.
// Each row passes the atlas read, the fetch stage and the output register, which holds a row.
// Synchronous active-low reset clears sequencer, pipeline valids and pen; the atlas keeps its data.
`timescale 1ns / 1ps

module bitmap_font_text_renderer
  import bftr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int CELL_WIDTH    = DEF_CELL_WIDTH,
  parameter int CELL_HEIGHT   = DEF_CELL_HEIGHT,
  parameter int ATLAS_WIDTH   = DEF_ATLAS_WIDTH,
  parameter int ATLAS_BYTES   = DEF_ATLAS_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  bftr_in_if.sink           in_chan,
  bftr_out_if.source        out_chan
);

  // Atlas addressing
  localparam int AW  = $clog2(ATLAS_BYTES);
  localparam int SYW = $clog2(CELL_HEIGHT + 1);

  // Row step through the atlas, in bytes plus a sub-byte bit offset
  localparam int STEP_BYTES = ATLAS_WIDTH / 8;
  localparam int STEP_BITS  = ATLAS_WIDTH % 8;

  // Start of each map row of cells in the atlas
  localparam int ROW1_BITS = CELL_HEIGHT * ATLAS_WIDTH;
  localparam int ROW2_BITS = 2 * CELL_HEIGHT * ATLAS_WIDTH;
  localparam int ROW1_BYTE = (ROW1_BITS / 8) % ATLAS_BYTES;
  localparam int ROW2_BYTE = (ROW2_BITS / 8) % ATLAS_BYTES;
  localparam int ROW1_BIT  = ROW1_BITS % 8;
  localparam int ROW2_BIT  = ROW2_BITS % 8;

  // Glyph rows need three atlas bytes when they can start off a byte boundary and are wide
  localparam bit ALIGNED = (ATLAS_WIDTH % 8 == 0) && (CELL_WIDTH % 8 == 0);
  localparam bit NB3     = !ALIGNED && (CELL_WIDTH > 9);

  localparam logic signed [16:0] SH = 17'(SCREEN_HEIGHT);
  localparam logic signed [16:0] SW = 17'(SCREEN_WIDTH);

  // Sequencer
  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;

  // Pen
  logic signed [15:0] pen_x_r;
  logic signed [15:0] pen_y_r;
  logic [15:0]        pen_color_r;

  // Current character
  cell_pos_t          cell_r;
  logic [SYW-1:0]     sy_r;
  logic signed [16:0] ya_r;
  logic [AW-1:0]      byte_r;
  logic [2:0]         bit_r;
  logic [15:0]        colmask_r;

  // Fetch stage: atlas data for one row waits here for the output register
  logic        pend_v_r;
  logic [2:0]  pend_bit_r;
  logic [7:0]  pend_y_r;
  logic        pend_last_r;
  logic [7:0]  lo_a_r;
  logic [7:0]  lo_b_r;

  // Output register
  logic               out_v_r;
  logic [7:0]         out_y_r;
  logic signed [15:0] out_x_r;
  logic [15:0]        out_mask_r;
  logic [15:0]        out_color_r;
  logic               out_last_r;

  // Control
  logic in_ready;
  logic accept;
  logic issue;
  logic issue_final;
  logic row_adv;
  logic pen_adv;
  logic can_load;
  logic can_issue;
  logic on_screen;
  logic row_last;
  logic emit_last;

  // Atlas RAM
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [AW-1:0] addr1;
  logic [AW-1:0] addr2;
  logic [7:0]    rd_a;
  logic [7:0]    rd_b;

  // Datapath helpers
  logic [16:0]     waddr_wrap;
  logic [8:0]      x0;
  logic [9:0]      start_bits;
  logic [AW:0]     row_byte;
  logic [2:0]      row_bit;
  logic [AW:0]     start_sum;
  logic [AW-1:0]   start_byte;
  logic [3:0]      next_bits;
  logic [AW:0]     next_sum;
  logic [AW-1:0]   next_byte;
  logic [15:0]     colmask;
  logic [23:0]     window;
  logic [23:0]     window_sh;
  logic [15:0]     row_mask;
  logic signed [16:0] pen_nx;

  assign accept   = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  assign can_load  = !out_v_r || out_chan.ready;
  assign can_issue = !pend_v_r || can_load;
  assign on_screen = (ya_r >= 17'sd0) && (ya_r < SH);
  assign row_last  = (sy_r == SYW'(CELL_HEIGHT - 1));
  assign emit_last = row_last || (ya_r == SH - 17'sd1);

  // ---------------------------------------------------------------------
  // Sequencer: idle takes items; a draw walks the glyph rows one per step
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    in_ready    = 1'b0;
    issue       = 1'b0;
    issue_final = 1'b0;
    row_adv     = 1'b0;
    pen_adv     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid && in_chan.kind == KIND_DRAW) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (!on_screen) begin
          // skip rows above or below the screen
          row_adv = 1'b1;
        end else if (NB3 && !phase_r) begin
          // first two bytes of a wide unaligned row
          if (can_issue) begin
            issue     = 1'b1;
            phase_nxt = 1'b1;
          end
        end else if (NB3) begin
          issue       = 1'b1;
          issue_final = 1'b1;
          row_adv     = 1'b1;
          phase_nxt   = 1'b0;
        end else if (can_issue) begin
          issue       = 1'b1;
          issue_final = 1'b1;
          row_adv     = 1'b1;
        end
        if (row_adv && row_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // drain the fetch stage before the pen moves on
        if (!pend_v_r) begin
          pen_adv   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Pen registers
  // ---------------------------------------------------------------------
  assign pen_nx = {pen_x_r[15], pen_x_r} + 17'(CELL_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      pen_color_r <= '0;
    end else if (accept && in_chan.kind == KIND_PEN) begin
      pen_x_r     <= in_chan.pen_x_in;
      pen_y_r     <= in_chan.pen_y_in;
      pen_color_r <= in_chan.color_in;
    end else if (pen_adv) begin
      // saturate at the top of the signed 16-bit range
      pen_x_r <= (!pen_nx[16] && pen_nx[15]) ? 16'sh7FFF : pen_nx[15:0];
    end
  end

  // ---------------------------------------------------------------------
  // Atlas load path: wrap the byte address into the atlas
  // ---------------------------------------------------------------------
  always_comb begin
    waddr_wrap = 17'(in_chan.atlas_addr);
    for (int i = 0; i < 8; i++) begin
      if (waddr_wrap >= 17'(ATLAS_BYTES)) begin
        waddr_wrap = waddr_wrap - 17'(ATLAS_BYTES);
      end
    end
  end

  assign mem_we    = accept && in_chan.kind == KIND_LOAD;
  assign mem_waddr = waddr_wrap[AW-1:0];

  // ---------------------------------------------------------------------
  // Setup: first atlas byte and bit of the cell, clip columns to the screen
  // ---------------------------------------------------------------------
  assign x0 = 9'(cell_r.col) * 9'(CELL_WIDTH);

  always_comb begin
    case (cell_r.row)
      2'd1: begin
        row_byte = (AW+1)'(ROW1_BYTE);
        row_bit  = 3'(ROW1_BIT);
      end
      2'd2: begin
        row_byte = (AW+1)'(ROW2_BYTE);
        row_bit  = 3'(ROW2_BIT);
      end
      default: begin
        row_byte = '0;
        row_bit  = '0;
      end
    endcase
  end

  assign start_bits = {1'b0, x0} + 10'(row_bit);
  assign start_sum  = row_byte + (AW+1)'(start_bits[9:3]);
  assign start_byte = (start_sum >= (AW+1)'(ATLAS_BYTES)) ?
                      AW'(start_sum - (AW+1)'(ATLAS_BYTES)) : start_sum[AW-1:0];

  always_comb begin
    logic signed [16:0] xk;
    for (int k = 0; k < 16; k++) begin
      xk = {pen_x_r[15], pen_x_r} + 17'(k);
      colmask[k] = (k < CELL_WIDTH) && (xk >= 17'sd0) && (xk < SW);
    end
  end

  // Row step: advance one atlas row, wrapping the byte address
  assign next_bits = {1'b0, bit_r} + 4'(STEP_BITS);
  assign next_sum  = {1'b0, byte_r} + (AW+1)'(STEP_BYTES) + (AW+1)'(next_bits[3]);
  assign next_byte = (next_sum >= (AW+1)'(ATLAS_BYTES)) ?
                     AW'(next_sum - (AW+1)'(ATLAS_BYTES)) : next_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && in_chan.kind == KIND_DRAW) begin
      cell_r <= glyph_cell(in_chan.char_code);
    end
    if (state_r == ST_SETUP) begin
      sy_r      <= '0;
      ya_r      <= {pen_y_r[15], pen_y_r};
      byte_r    <= start_byte;
      bit_r     <= start_bits[2:0];
      colmask_r <= colmask;
    end else if (row_adv) begin
      sy_r   <= sy_r + SYW'(1);
      ya_r   <= ya_r + 17'sd1;
      byte_r <= next_byte;
      bit_r  <= next_bits[2:0];
    end
  end

  // ---------------------------------------------------------------------
  // Atlas reads: consecutive bytes of the row, wrapping at the atlas end
  // ---------------------------------------------------------------------
  assign addr1   = (byte_r == AW'(ATLAS_BYTES - 1)) ? '0 : byte_r + AW'(1);
  assign addr2   = (addr1 == AW'(ATLAS_BYTES - 1)) ? '0 : addr1 + AW'(1);
  assign raddr_a = phase_r ? addr2 : byte_r;
  assign raddr_b = addr1;

  bftr_atlas #(
    .DEPTH (ATLAS_BYTES),
    .AW    (AW)
  ) u_atlas (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (in_chan.atlas_byte),
    .re      (issue),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // ---------------------------------------------------------------------
  // Fetch stage bookkeeping
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (issue_final) begin
      pend_v_r <= 1'b1;
    end else if (pend_v_r && can_load) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_final) begin
      pend_bit_r  <= bit_r;
      pend_y_r    <= ya_r[7:0];
      pend_last_r <= emit_last;
    end
    // keep the first two bytes while the third is read
    if (issue && phase_r) begin
      lo_a_r <= rd_a;
      lo_b_r <= rd_b;
    end
  end

  // Row mask: align the fetched bytes, then clip to cell and screen
  assign window    = NB3 ? {lo_a_r, lo_b_r, rd_a} : {rd_a, rd_b, 8'h00};
  assign window_sh = window << pend_bit_r;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      row_mask[k] = window_sh[23-k] & colmask_r[k];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (pend_v_r && can_load) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_v_r && can_load) begin
      out_y_r     <= pend_y_r;
      out_x_r     <= pen_x_r;
      out_mask_r  <= row_mask;
      out_color_r <= pen_color_r;
      out_last_r  <= pend_last_r;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.screen_y   = out_y_r;
  assign out_chan.screen_x   = out_x_r;
  assign out_chan.write_mask = out_mask_r;
  assign out_chan.color      = out_color_r;
  assign out_chan.last       = out_last_r;

`ifndef SYNTHESIS
  // No new item while a row still sits in the fetch stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !pend_v_r)
    else $error("item taken while a glyph row is still in flight");

  // The second fetch cycle of a wide row always finds the fetch stage empty
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !pend_v_r)
    else $error("second atlas fetch overlaps a pending row");

  // A row enters the fetch stage only from the row walk
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_v_r) |-> $past(state_r) == ST_ROW)
    else $error("fetch stage loaded outside the row walk");

  // The sequencer leaves idle with the fetch phase cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !phase_r)
    else $error("fetch phase left set in idle");
`endif

endmodule
